// ----- src/amce_pkg.sv -----
// ----------------------------------------------------------------------------
// Affine matrix compose engine package
// Opcodes and sequencer state encoding used by the engine unit.
// ----------------------------------------------------------------------------
package amce_pkg;

    typedef enum logic [3:0] {
        OP_IDENTITY = 4'd0,
        OP_LOAD     = 4'd1,
        OP_MULTIPLY = 4'd2,
        OP_TRANSLATE= 4'd3,
        OP_SCALE    = 4'd4,
        OP_ROTATE   = 4'd5,
        OP_SHEAR    = 4'd6,
        OP_INVERT   = 4'd7,
        OP_INVMAP   = 4'd8
    } opcode_t;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MAC  = 6'b000010,
        ST_DET  = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_STORE= 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

endpackage

// ----- src/affine_matrix_compose_engine_unit.sv -----
// ----------------------------------------------------------------------------
// Affine matrix compose engine
// Holds a 2D affine matrix and composes, inverts or inverse-maps with it.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake          | Payload
// s_      | in        | s_valid / s_ready  | opcode, operand matrix, args, pivot
// m_      | out       | m_valid / m_ready  | result matrix, point, singular
//
// Load, identity and unused opcodes go straight to the output. Composing opcodes
// take one step per product or shifted term over all six coefficients plus one
// per untouched coefficient, all through one shared multiplier. Each quotient of
// invert and inverse map is formed in the bit-serial divider (NW = 85 by
// default), and a zero determinant ends either once the determinant is known.
// aresetn is synchronous and active low and restores the identity matrix.
// s_ready is low from acceptance until the result has been taken.
module affine_matrix_compose_engine_unit #(
    parameter int COEF_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [3:0]          s_opcode,
    input  logic signed [31:0]  s_op_m00,
    input  logic signed [31:0]  s_op_m01,
    input  logic signed [31:0]  s_op_m10,
    input  logic signed [31:0]  s_op_m11,
    input  logic signed [31:0]  s_op_m20,
    input  logic signed [31:0]  s_op_m21,
    input  logic signed [31:0]  s_arg_x,
    input  logic signed [31:0]  s_arg_y,
    input  logic signed [31:0]  s_pivot_x,
    input  logic signed [31:0]  s_pivot_y,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [31:0]  m_res_m00,
    output logic signed [31:0]  m_res_m01,
    output logic signed [31:0]  m_res_m10,
    output logic signed [31:0]  m_res_m11,
    output logic signed [31:0]  m_res_m20,
    output logic signed [31:0]  m_res_m21,
    output logic signed [31:0]  m_point_x,
    output logic signed [31:0]  m_point_y,
    output logic                m_singular
);
    localparam int W   = COEF_WIDTH;
    localparam int PW  = 2 * W;
    // accumulator with headroom for products and shifted terms
    localparam int AW  = ((W > FRAC_BITS) ? PW : W + FRAC_BITS) + 4;
    localparam int NW  = AW + FRAC_BITS + 1; // shifted dividend
    localparam int DCW = $clog2(NW + 1);
    localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] ONE_Q =
        (FRAC_BITS >= W - 1) ? CMAX : W'(1) << FRAC_BITS;

    // Sign-extend or saturate a 32-bit field to the coefficient width.
    function automatic logic signed [W-1:0] clampc(input logic signed [31:0] v);
        logic signed [95:0] e;
        e = 96'(v);
        if (e > 96'(CMAX)) return CMAX;
        if (e < 96'(CMIN)) return CMIN;
        return W'(e);
    endfunction

    // Saturate a signed wide value to the coefficient width.
    function automatic logic signed [W-1:0] satw(input logic signed [NW-1:0] v);
        if (v > NW'(CMAX)) return CMAX;
        if (v < NW'(CMIN)) return CMIN;
        return W'(v);
    endfunction

    amce_pkg::state_t state_reg, state_next;
    logic signed [W-1:0] m_reg [6];
    logic signed [W-1:0] n_reg [6];
    logic signed [W-1:0] f_reg [10];
    logic [3:0]          op_reg;
    logic [2:0]          coef_reg;   // coefficient being computed
    logic [2:0]          term_reg;   // term index within it
    logic signed [AW-1:0] acc_reg;
    logic signed [AW-1:0] det_reg;
    logic                 sing_reg;
    logic signed [W-1:0]  px_reg, py_reg;
    // divider
    logic [NW-1:0]   dn_reg, dq_reg;
    logic [AW-1:0]   dd_reg;
    logic [NW:0]     dr_reg;
    logic            dneg_reg;
    logic [DCW-1:0]  dcnt_reg;
    // shared multiplier
    logic signed [W-1:0]  mul_a, mul_b;
    logic signed [AW-1:0] mprod;

    // ---- term table: a*b, sub, or addq (a << FRAC) ----
    logic signed [W-1:0] ta, tb;
    logic                tsub, tshift, tlast, tvalid;
    always_comb begin
        logic signed [W-1:0] ax, ay, cx, cy;
        ax = f_reg[6]; ay = f_reg[7]; cx = f_reg[8]; cy = f_reg[9];
        ta = '0; tb = '0; tsub = 1'b0; tshift = 1'b0; tlast = 1'b1; tvalid = 1'b0;
        unique case (op_reg)
            amce_pkg::OP_MULTIPLY: begin
                tvalid = 1'b1;
                tlast = (coef_reg < 3'd4) ? (term_reg == 3'd1) : (term_reg == 3'd2);
                ta = m_reg[{coef_reg[2:1], 1'b0} + 3'(term_reg[0])];
                tb = f_reg[{3'b0, coef_reg[0]} + (term_reg[0] ? 4'd2 : 4'd0)];
                if (term_reg == 3'd2) begin
                    tshift = 1'b1; ta = f_reg[4'd4 + 4'(coef_reg[0])];
                end
            end
            amce_pkg::OP_TRANSLATE: begin
                tvalid = coef_reg[2]; tshift = 1'b1; tlast = (term_reg == 3'd1);
                ta = (term_reg == 3'd0) ? m_reg[coef_reg] : (coef_reg[0] ? ay : ax);
            end
            amce_pkg::OP_SCALE: begin
                tvalid = 1'b1;
                tb = coef_reg[0] ? ay : ax;
                tlast = coef_reg[2] ? (term_reg == 3'd2) : 1'b1;
                ta = m_reg[coef_reg];
                if (term_reg == 3'd1) begin
                    ta = coef_reg[0] ? cy : cx; tsub = 1'b1;
                end
                if (term_reg == 3'd2) begin
                    ta = coef_reg[0] ? cy : cx; tshift = 1'b1;
                end
            end
            amce_pkg::OP_ROTATE: begin
                tvalid = 1'b1;
                if (!coef_reg[2]) begin
                    tlast = (term_reg == 3'd1);
                    ta = m_reg[{1'b0, coef_reg[1], term_reg[0]}];
                    tb = (coef_reg[0] ^ term_reg[0]) ? ay : ax;
                    tsub = !coef_reg[0] && term_reg[0];
                end else begin
                    tlast = (term_reg == 3'd4);
                    unique case (term_reg)
                        3'd0: begin ta = m_reg[4]; tb = coef_reg[0] ? ay : ax; end
                        3'd1: begin ta = cx; tb = coef_reg[0] ? ay : ax; tsub = 1'b1; end
                        3'd2: begin ta = m_reg[5]; tb = coef_reg[0] ? ax : ay;
                                    tsub = !coef_reg[0]; end
                        3'd3: begin ta = cy; tb = coef_reg[0] ? ax : ay;
                                    tsub = coef_reg[0]; end
                        default: begin ta = coef_reg[0] ? cy : cx; tshift = 1'b1; end
                    endcase
                end
            end
            amce_pkg::OP_SHEAR: begin
                tvalid = 1'b1;
                tlast = coef_reg[2] ? (term_reg == 3'd2) : (term_reg == 3'd1);
                tb = coef_reg[0] ? ay : ax;
                ta = m_reg[coef_reg ^ 3'd1];
                if (term_reg == 3'd1 && coef_reg[2]) begin
                    ta = coef_reg[0] ? cx : cy; tsub = 1'b1;
                end
                if (term_reg == 3'd1 && !coef_reg[2]) begin
                    ta = m_reg[coef_reg]; tshift = 1'b1;
                end
                if (term_reg == 3'd2) begin
                    ta = m_reg[coef_reg]; tshift = 1'b1;
                end
            end
            default: begin end
        endcase
    end

    // Accumulator step for the composing opcodes.
    logic signed [AW-1:0] prod, term, acc_sum;
    logic signed [NW-1:0] acc_tr;
    always_comb begin
        prod = mprod;
        if (tshift) prod = AW'(ta) <<< FRAC_BITS;
        term = tsub ? -prod : prod;
        acc_sum = acc_reg + term;
        // truncate toward zero then saturate
        if (acc_sum < 0)
            acc_tr = -(NW'(-acc_sum) >>> FRAC_BITS);
        else
            acc_tr = NW'(acc_sum) >>> FRAC_BITS;
    end

    // Divider operands selected by quotient index (coef_reg in DIV).
    logic signed [NW-1:0] div_num;
    always_comb begin
        div_num = '0;
        if (op_reg == amce_pkg::OP_INVERT) begin
            unique case (coef_reg)
                3'd0: div_num = NW'(m_reg[3]) <<< (2*FRAC_BITS);
                3'd1: div_num = -(NW'(m_reg[1]) <<< (2*FRAC_BITS));
                3'd2: div_num = -(NW'(m_reg[2]) <<< (2*FRAC_BITS));
                3'd3: div_num = NW'(m_reg[0]) <<< (2*FRAC_BITS);
                3'd4: div_num = NW'(acc_reg) <<< FRAC_BITS;
                default: div_num = -(NW'(acc_reg) <<< FRAC_BITS);
            endcase
        end else begin
            div_num = NW'(acc_reg) <<< FRAC_BITS;
        end
    end

    // Per-coefficient cross terms for invert/map run through the MAC in ST_DET.
    logic signed [W-1:0] da, db;
    logic                dsub;
    always_comb begin
        da = '0; db = '0; dsub = 1'b0;
        // coef_reg 7 is the determinant itself
        if (coef_reg == 3'd7) begin
            da = term_reg[0] ? m_reg[1] : m_reg[0];
            db = term_reg[0] ? m_reg[2] : m_reg[3];
            dsub = term_reg[0];
        end else if (op_reg == amce_pkg::OP_INVERT) begin
            if (coef_reg == 3'd4) begin
                da = term_reg[0] ? m_reg[3] : m_reg[2];
                db = term_reg[0] ? m_reg[4] : m_reg[5];
            end else begin
                da = term_reg[0] ? m_reg[1] : m_reg[0];
                db = term_reg[0] ? m_reg[4] : m_reg[5];
            end
            dsub = term_reg[0];
        end else if (coef_reg == 3'd0) begin
            unique case (term_reg[1:0])
                2'd0: begin da = m_reg[3]; db = f_reg[6]; end
                2'd1: begin da = m_reg[2]; db = f_reg[7]; dsub = 1'b1; end
                2'd2: begin da = m_reg[2]; db = m_reg[5]; end
                default: begin da = m_reg[3]; db = m_reg[4]; dsub = 1'b1; end
            endcase
        end else begin
            unique case (term_reg[1:0])
                2'd0: begin da = m_reg[0]; db = f_reg[7]; end
                2'd1: begin da = m_reg[1]; db = f_reg[6]; dsub = 1'b1; end
                2'd2: begin da = m_reg[1]; db = m_reg[4]; end
                default: begin da = m_reg[0]; db = m_reg[5]; dsub = 1'b1; end
            endcase
        end
    end

    // One multiplier serves both the composing terms and the determinant terms.
    assign mul_a = (state_reg == amce_pkg::ST_DET) ? da : ta;
    assign mul_b = (state_reg == amce_pkg::ST_DET) ? db : tb;
    assign mprod = AW'(mul_a * mul_b);

    logic signed [AW-1:0] dprod, dsum;
    assign dprod = mprod;
    assign dsum  = acc_reg + (dsub ? -dprod : dprod);
    logic dlast;
    assign dlast = (coef_reg == 3'd7 || op_reg == amce_pkg::OP_INVERT)
                   ? (term_reg == 3'd1) : (term_reg == 3'd3);

    // restoring divider step
    logic [NW:0] dr_sh, dr_sub;
    assign dr_sh  = {dr_reg[NW-1:0], dn_reg[NW-1]};
    assign dr_sub = dr_sh - (NW+1)'(dd_reg);
    logic signed [NW-1:0] qsigned;
    assign qsigned = dneg_reg ? -$signed(dq_reg) : $signed(dq_reg);

    logic signed [W-1:0] fin [10];
    assign fin[0] = clampc(s_op_m00); assign fin[1] = clampc(s_op_m01);
    assign fin[2] = clampc(s_op_m10); assign fin[3] = clampc(s_op_m11);
    assign fin[4] = clampc(s_op_m20); assign fin[5] = clampc(s_op_m21);
    assign fin[6] = clampc(s_arg_x);  assign fin[7] = clampc(s_arg_y);
    assign fin[8] = clampc(s_pivot_x); assign fin[9] = clampc(s_pivot_y);

    logic last_coef;
    assign last_coef = (coef_reg == 3'd5);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= amce_pkg::ST_IDLE;
            m_reg[0] <= ONE_Q; m_reg[1] <= '0; m_reg[2] <= '0;
            m_reg[3] <= ONE_Q; m_reg[4] <= '0; m_reg[5] <= '0;
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                amce_pkg::ST_IDLE: if (s_valid) begin
                    op_reg <= s_opcode;
                    for (int i = 0; i < 10; i++) f_reg[i] <= fin[i];
                    for (int i = 0; i < 6; i++) begin
                        if (s_opcode == amce_pkg::OP_LOAD)
                            n_reg[i] <= fin[i];
                        else if (s_opcode == amce_pkg::OP_IDENTITY)
                            n_reg[i] <= (i == 0 || i == 3) ? ONE_Q : '0;
                        else
                            n_reg[i] <= m_reg[i];
                    end
                    term_reg <= 3'd0; acc_reg <= '0;
                    sing_reg <= 1'b0; px_reg <= '0; py_reg <= '0;
                    if (s_opcode == amce_pkg::OP_INVERT || s_opcode == amce_pkg::OP_INVMAP)
                        coef_reg <= 3'd7;
                    else
                        coef_reg <= 3'd0;
                end
                amce_pkg::ST_MAC: begin
                    if (!tvalid) begin
                        coef_reg <= coef_reg + 3'd1; term_reg <= '0;
                    end else if (tlast) begin
                        n_reg[coef_reg] <= satw(acc_tr);
                        acc_reg <= '0; term_reg <= '0; coef_reg <= coef_reg + 3'd1;
                    end else begin
                        acc_reg <= acc_sum; term_reg <= term_reg + 3'd1;
                    end
                end
                amce_pkg::ST_DET: begin
                    if (dlast) begin
                        term_reg <= '0;
                        if (coef_reg == 3'd7) begin
                            det_reg <= dsum; acc_reg <= '0;
                            if (dsum == '0) sing_reg <= 1'b1;
                            coef_reg <= 3'd0;
                        end else acc_reg <= dsum;
                    end else begin
                        acc_reg <= dsum; term_reg <= term_reg + 3'd1;
                    end
                    if (state_next == amce_pkg::ST_DIV) begin
                        dneg_reg <= 1'b0; dcnt_reg <= DCW'(NW);
                    end
                end
                amce_pkg::ST_DIV: begin
                    if (dcnt_reg == DCW'(NW)) begin
                        // The magnitude's top bit is always zero, so it is skipped.
                        dn_reg <= div_num[NW-1] ? NW'(-div_num) << 1 : NW'(div_num) << 1;
                        dd_reg <= det_reg[AW-1] ? AW'(-det_reg) : AW'(det_reg);
                        dneg_reg <= div_num[NW-1] ^ det_reg[AW-1];
                        dr_reg <= '0; dq_reg <= '0;
                        dcnt_reg <= dcnt_reg - DCW'(1);
                    end else if (dcnt_reg != '0) begin
                        dn_reg <= dn_reg << 1;
                        if (!dr_sub[NW]) begin
                            dr_reg <= dr_sub; dq_reg <= {dq_reg[NW-2:0], 1'b1};
                        end else begin
                            dr_reg <= dr_sh; dq_reg <= {dq_reg[NW-2:0], 1'b0};
                        end
                        dcnt_reg <= dcnt_reg - DCW'(1);
                    end
                end
                amce_pkg::ST_STORE: begin
                    if (op_reg == amce_pkg::OP_INVERT) n_reg[coef_reg] <= satw(qsigned);
                    else if (coef_reg == 3'd0) px_reg <= satw(qsigned);
                    else py_reg <= satw(qsigned);
                    coef_reg <= coef_reg + 3'd1; acc_reg <= '0;
                    dcnt_reg <= DCW'(NW);
                end
                amce_pkg::ST_OUT: if (m_ready) begin
                    for (int i = 0; i < 6; i++) m_reg[i] <= n_reg[i];
                end
                default: begin end
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            amce_pkg::ST_IDLE: if (s_valid) begin
                if (s_opcode == amce_pkg::OP_INVERT || s_opcode == amce_pkg::OP_INVMAP)
                    state_next = amce_pkg::ST_DET;
                else if (s_opcode >= amce_pkg::OP_MULTIPLY && s_opcode <= amce_pkg::OP_SHEAR)
                    state_next = amce_pkg::ST_MAC;
                else state_next = amce_pkg::ST_OUT;
            end
            amce_pkg::ST_MAC:
                if (last_coef && (tlast || !tvalid)) state_next = amce_pkg::ST_OUT;
            amce_pkg::ST_DET: if (dlast) begin
                if (coef_reg == 3'd7) begin
                    if (dsum == '0) state_next = amce_pkg::ST_OUT;
                    else if (op_reg == amce_pkg::OP_INVERT) state_next = amce_pkg::ST_DIV;
                end else state_next = amce_pkg::ST_DIV;
            end
            amce_pkg::ST_DIV: if (dcnt_reg == '0) state_next = amce_pkg::ST_STORE;
            amce_pkg::ST_STORE: begin
                if (op_reg == amce_pkg::OP_INVERT)
                    state_next = last_coef ? amce_pkg::ST_OUT :
                                 (coef_reg >= 3'd3 ? amce_pkg::ST_DET : amce_pkg::ST_DIV);
                else state_next = (coef_reg == 3'd1) ? amce_pkg::ST_OUT : amce_pkg::ST_DET;
            end
            amce_pkg::ST_OUT: if (m_ready) state_next = amce_pkg::ST_IDLE;
            default: state_next = amce_pkg::ST_IDLE;
        endcase
    end

    assign s_ready    = (state_reg == amce_pkg::ST_IDLE);
    assign m_valid    = (state_reg == amce_pkg::ST_OUT);
    assign m_res_m00  = 32'(n_reg[0]);
    assign m_res_m01  = 32'(n_reg[1]);
    assign m_res_m10  = 32'(n_reg[2]);
    assign m_res_m11  = 32'(n_reg[3]);
    assign m_res_m20  = 32'(n_reg[4]);
    assign m_res_m21  = 32'(n_reg[5]);
    assign m_point_x  = 32'(px_reg);
    assign m_point_y  = 32'(py_reg);
    assign m_singular = sing_reg;
endmodule

// ----- src/amce_checker.sv -----
// ----------------------------------------------------------------------------
// Affine matrix compose engine port checker
// Watches the handshake ports of the engine over time.
// ----------------------------------------------------------------------------
module amce_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_point_x,
    input logic        m_singular
);
    // A request is never taken while a result waits.
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("input ready while result pending");
    // A result stays until it is taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid) else $error("result dropped");
    // The input side goes busy right after a request is accepted.
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready) else $error("ready after accept");
    // A singular result carries a zero x coordinate.
    a_sing: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_singular |-> m_point_x == '0) else $error("point on singular");
endmodule

bind affine_matrix_compose_engine_unit amce_checker u_amce_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_point_x(m_point_x),
    .m_singular(m_singular)
);
